// File: rtl/core/c8dec_pkg.sv
// Shared types and codes for the CHIP-8 / SuperChip instruction decoder.
package c8dec_pkg;

  localparam int unsigned OPC_W  = 16;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned MNEM_W = 6;
  localparam int unsigned CLS_W  = 4;
  localparam int unsigned FORM_W = 4;
  localparam int unsigned REG_W  = 4;
  localparam int unsigned IMM_W  = 12;

  localparam logic [ADDR_W-1:0] SKIP_DIST = 16'd4;

  localparam logic [OPC_W-1:0] OP_CLS     = 16'h00E0;
  localparam logic [OPC_W-1:0] OP_RTS     = 16'h00EE;
  localparam logic [OPC_W-1:0] OP_SCRIGHT = 16'h00FB;
  localparam logic [OPC_W-1:0] OP_SCLEFT  = 16'h00FC;
  localparam logic [OPC_W-1:0] OP_LOW     = 16'h00FE;
  localparam logic [OPC_W-1:0] OP_HIGH    = 16'h00FF;
  localparam logic [11:0]      OP_SCDOWN_HI = 12'h00C;

  localparam logic [7:0] KK_SKP    = 8'h9E;
  localparam logic [7:0] KK_SKNP   = 8'hA1;
  localparam logic [7:0] KK_GDELAY = 8'h07;
  localparam logic [7:0] KK_WKEY   = 8'h0A;
  localparam logic [7:0] KK_SDELAY = 8'h15;
  localparam logic [7:0] KK_SSOUND = 8'h18;
  localparam logic [7:0] KK_ADDI   = 8'h1E;
  localparam logic [7:0] KK_FONT   = 8'h29;
  localparam logic [7:0] KK_XFONT  = 8'h30;
  localparam logic [7:0] KK_BCD    = 8'h33;
  localparam logic [7:0] KK_STRA   = 8'h55;
  localparam logic [7:0] KK_LDRA   = 8'h65;

  localparam logic [3:0] GRP_SYS   = 4'h0;
  localparam logic [3:0] GRP_JMP   = 4'h1;
  localparam logic [3:0] GRP_CALL  = 4'h2;
  localparam logic [3:0] GRP_SKEI  = 4'h3;
  localparam logic [3:0] GRP_SKNEI = 4'h4;
  localparam logic [3:0] GRP_SKER  = 4'h5;
  localparam logic [3:0] GRP_MOVI  = 4'h6;
  localparam logic [3:0] GRP_ADDI  = 4'h7;
  localparam logic [3:0] GRP_ALU   = 4'h8;
  localparam logic [3:0] GRP_SKNER = 4'h9;
  localparam logic [3:0] GRP_LDI   = 4'hA;
  localparam logic [3:0] GRP_JMPV  = 4'hB;
  localparam logic [3:0] GRP_RAND  = 4'hC;
  localparam logic [3:0] GRP_DRAW  = 4'hD;
  localparam logic [3:0] GRP_KEY   = 4'hE;
  localparam logic [3:0] GRP_MISC  = 4'hF;

  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [MNEM_W-1:0] MN_CLS     = 6'd0;
  localparam logic [MNEM_W-1:0] MN_RTS     = 6'd1;
  localparam logic [MNEM_W-1:0] MN_SCRIGHT = 6'd2;
  localparam logic [MNEM_W-1:0] MN_SCLEFT  = 6'd3;
  localparam logic [MNEM_W-1:0] MN_LOW     = 6'd4;
  localparam logic [MNEM_W-1:0] MN_HIGH    = 6'd5;
  localparam logic [MNEM_W-1:0] MN_SCDOWN  = 6'd6;
  localparam logic [MNEM_W-1:0] MN_SYS     = 6'd7;
  localparam logic [MNEM_W-1:0] MN_JMP     = 6'd8;
  localparam logic [MNEM_W-1:0] MN_CALL    = 6'd9;
  localparam logic [MNEM_W-1:0] MN_SKE     = 6'd10;
  localparam logic [MNEM_W-1:0] MN_SKNE    = 6'd11;
  localparam logic [MNEM_W-1:0] MN_MOV     = 6'd12;
  localparam logic [MNEM_W-1:0] MN_ADD     = 6'd13;
  localparam logic [MNEM_W-1:0] MN_OR      = 6'd14;
  localparam logic [MNEM_W-1:0] MN_AND     = 6'd15;
  localparam logic [MNEM_W-1:0] MN_XOR     = 6'd16;
  localparam logic [MNEM_W-1:0] MN_SUB     = 6'd17;
  localparam logic [MNEM_W-1:0] MN_SHR     = 6'd18;
  localparam logic [MNEM_W-1:0] MN_SHL     = 6'd19;
  localparam logic [MNEM_W-1:0] MN_RAND    = 6'd20;
  localparam logic [MNEM_W-1:0] MN_DRAW    = 6'd21;
  localparam logic [MNEM_W-1:0] MN_SKP     = 6'd22;
  localparam logic [MNEM_W-1:0] MN_SKNP    = 6'd23;
  localparam logic [MNEM_W-1:0] MN_GDELAY  = 6'd24;
  localparam logic [MNEM_W-1:0] MN_WKEY    = 6'd25;
  localparam logic [MNEM_W-1:0] MN_SDELAY  = 6'd26;
  localparam logic [MNEM_W-1:0] MN_SSOUND  = 6'd27;
  localparam logic [MNEM_W-1:0] MN_FONT    = 6'd28;
  localparam logic [MNEM_W-1:0] MN_XFONT   = 6'd29;
  localparam logic [MNEM_W-1:0] MN_BCD     = 6'd30;
  localparam logic [MNEM_W-1:0] MN_STRA    = 6'd31;
  localparam logic [MNEM_W-1:0] MN_LDRA    = 6'd32;

  localparam logic [CLS_W-1:0] CL_NONE     = 4'd0;
  localparam logic [CLS_W-1:0] CL_STOP     = 4'd1;
  localparam logic [CLS_W-1:0] CL_JUMP     = 4'd2;
  localparam logic [CLS_W-1:0] CL_CONDJUMP = 4'd3;
  localparam logic [CLS_W-1:0] CL_CALL     = 4'd4;
  localparam logic [CLS_W-1:0] CL_ADD      = 4'd5;
  localparam logic [CLS_W-1:0] CL_SUB      = 4'd6;
  localparam logic [CLS_W-1:0] CL_AND      = 4'd7;
  localparam logic [CLS_W-1:0] CL_OR       = 4'd8;
  localparam logic [CLS_W-1:0] CL_XOR      = 4'd9;
  localparam logic [CLS_W-1:0] CL_LOAD     = 4'd10;
  localparam logic [CLS_W-1:0] CL_STORE    = 4'd11;
  localparam logic [CLS_W-1:0] CL_PRIV     = 4'd12;

  localparam logic [FORM_W-1:0] FM_NONE      = 4'd0;
  localparam logic [FORM_W-1:0] FM_NIBBLE    = 4'd1;
  localparam logic [FORM_W-1:0] FM_CONST12   = 4'd2;
  localparam logic [FORM_W-1:0] FM_TARGET12  = 4'd3;
  localparam logic [FORM_W-1:0] FM_REG_IMM8  = 4'd4;
  localparam logic [FORM_W-1:0] FM_REG_REG   = 4'd5;
  localparam logic [FORM_W-1:0] FM_REG_C8    = 4'd6;
  localparam logic [FORM_W-1:0] FM_I_C12     = 4'd7;
  localparam logic [FORM_W-1:0] FM_V0_DISP   = 4'd8;
  localparam logic [FORM_W-1:0] FM_REG_REG_N = 4'd9;
  localparam logic [FORM_W-1:0] FM_KEY_REG   = 4'd10;
  localparam logic [FORM_W-1:0] FM_I_REG     = 4'd11;
  localparam logic [FORM_W-1:0] FM_REG       = 4'd12;
  localparam logic [FORM_W-1:0] FM_REG_SKIP  = 4'd13;

  typedef struct packed {
    logic              is_valid;
    logic [MNEM_W-1:0] mnemonic_code;
    logic [CLS_W-1:0]  insn_class;
    logic [FORM_W-1:0] operand_form;
    logic [REG_W-1:0]  reg_x;
    logic [REG_W-1:0]  reg_y;
    logic [IMM_W-1:0]  imm_value;
    logic              has_target;
    logic [ADDR_W-1:0] branch_target;
  } dec_t;

endpackage

// File: rtl/core/c8dec_decode.sv
// Combinational decode of one opcode word into a decoded request record.
module c8dec_decode
  import c8dec_pkg::*;
(
  input  logic [OPC_W-1:0]  opcode,
  input  logic [ADDR_W-1:0] address,
  output dec_t              dec
);

  logic [REG_W-1:0]  x;
  logic [REG_W-1:0]  y;
  logic [3:0]        n;
  logic [7:0]        kk;
  logic [IMM_W-1:0]  nnn;
  logic [ADDR_W-1:0] skip;

  assign x    = opcode[11:8];
  assign y    = opcode[7:4];
  assign n    = opcode[3:0];
  assign kk   = opcode[7:0];
  assign nnn  = opcode[11:0];
  assign skip = address + SKIP_DIST;

  always_comb begin
    dec = '0;
    unique case (opcode[15:12])
      GRP_SYS: begin
        dec.is_valid = 1'b1;
        priority if (opcode == OP_CLS) begin
          dec.mnemonic_code = MN_CLS;
        end else if (opcode == OP_RTS) begin
          dec.mnemonic_code = MN_RTS;
          dec.insn_class    = CL_STOP;
        end else if (opcode == OP_SCRIGHT) begin
          dec.mnemonic_code = MN_SCRIGHT;
        end else if (opcode == OP_SCLEFT) begin
          dec.mnemonic_code = MN_SCLEFT;
        end else if (opcode == OP_LOW) begin
          dec.mnemonic_code = MN_LOW;
        end else if (opcode == OP_HIGH) begin
          dec.mnemonic_code = MN_HIGH;
        end else if (opcode[15:4] == OP_SCDOWN_HI) begin
          dec.mnemonic_code = MN_SCDOWN;
          dec.operand_form  = FM_NIBBLE;
          dec.imm_value     = {8'd0, n};
        end else begin
          dec.mnemonic_code = MN_SYS;
          dec.insn_class    = CL_PRIV;
          dec.operand_form  = FM_CONST12;
          dec.imm_value     = nnn;
        end
      end
      GRP_JMP, GRP_CALL: begin
        dec.is_valid      = 1'b1;
        dec.mnemonic_code = (opcode[15:12] == GRP_JMP) ? MN_JMP : MN_CALL;
        dec.insn_class    = (opcode[15:12] == GRP_JMP) ? CL_JUMP : CL_CALL;
        dec.operand_form  = FM_TARGET12;
        dec.imm_value     = nnn;
        dec.has_target    = 1'b1;
        dec.branch_target = {4'd0, nnn};
      end
      GRP_SKEI, GRP_SKNEI: begin
        dec.is_valid      = 1'b1;
        dec.mnemonic_code = (opcode[15:12] == GRP_SKEI) ? MN_SKE : MN_SKNE;
        dec.insn_class    = CL_CONDJUMP;
        dec.operand_form  = FM_REG_IMM8;
        dec.reg_x         = x;
        dec.imm_value     = {4'd0, kk};
        dec.has_target    = 1'b1;
        dec.branch_target = skip;
      end
      GRP_SKER, GRP_SKNER: begin
        if (n == 4'd0) begin
          dec.is_valid      = 1'b1;
          dec.mnemonic_code = (opcode[15:12] == GRP_SKER) ? MN_SKE : MN_SKNE;
          dec.insn_class    = CL_CONDJUMP;
          dec.operand_form  = FM_REG_SKIP;
          dec.reg_x         = x;
          dec.reg_y         = y;
          dec.has_target    = 1'b1;
          dec.branch_target = skip;
        end
      end
      GRP_MOVI, GRP_ADDI: begin
        dec.is_valid      = 1'b1;
        dec.mnemonic_code = (opcode[15:12] == GRP_MOVI) ? MN_MOV : MN_ADD;
        dec.insn_class    = (opcode[15:12] == GRP_MOVI) ? CL_LOAD : CL_ADD;
        dec.operand_form  = FM_REG_C8;
        dec.reg_x         = x;
        dec.imm_value     = {4'd0, kk};
      end
      GRP_ALU: begin
        dec.is_valid     = 1'b1;
        dec.operand_form = FM_REG_REG;
        dec.reg_x        = x;
        dec.reg_y        = y;
        unique case (n)
          ALU_MOV: begin
            dec.mnemonic_code = MN_MOV;
            dec.insn_class    = CL_LOAD;
          end
          ALU_OR: begin
            dec.mnemonic_code = MN_OR;
            dec.insn_class    = CL_OR;
          end
          ALU_AND: begin
            dec.mnemonic_code = MN_AND;
            dec.insn_class    = CL_AND;
          end
          ALU_XOR: begin
            dec.mnemonic_code = MN_XOR;
            dec.insn_class    = CL_XOR;
          end
          ALU_ADD: begin
            dec.mnemonic_code = MN_ADD;
            dec.insn_class    = CL_ADD;
          end
          ALU_SUB, ALU_SUBN: begin
            dec.mnemonic_code = MN_SUB;
            dec.insn_class    = CL_SUB;
          end
          ALU_SHR, ALU_SHL: begin
            dec.mnemonic_code = (n == ALU_SHR) ? MN_SHR : MN_SHL;
            dec.operand_form  = FM_REG;
            dec.reg_y         = '0;
          end
          default: begin
            dec = '0;
          end
        endcase
      end
      GRP_LDI: begin
        dec.is_valid      = 1'b1;
        dec.mnemonic_code = MN_MOV;
        dec.insn_class    = CL_LOAD;
        dec.operand_form  = FM_I_C12;
        dec.imm_value     = nnn;
      end
      GRP_JMPV: begin
        dec.is_valid      = 1'b1;
        dec.mnemonic_code = MN_JMP;
        dec.insn_class    = CL_JUMP;
        dec.operand_form  = FM_V0_DISP;
        dec.imm_value     = nnn;
      end
      GRP_RAND: begin
        dec.is_valid      = 1'b1;
        dec.mnemonic_code = MN_RAND;
        dec.operand_form  = FM_REG_C8;
        dec.reg_x         = x;
        dec.imm_value     = {4'd0, kk};
      end
      GRP_DRAW: begin
        dec.is_valid      = 1'b1;
        dec.mnemonic_code = MN_DRAW;
        dec.operand_form  = FM_REG_REG_N;
        dec.reg_x         = x;
        dec.reg_y         = y;
        dec.imm_value     = {8'd0, n};
      end
      GRP_KEY: begin
        if ((kk == KK_SKP) || (kk == KK_SKNP)) begin
          dec.is_valid      = 1'b1;
          dec.mnemonic_code = (kk == KK_SKP) ? MN_SKP : MN_SKNP;
          dec.insn_class    = CL_CONDJUMP;
          dec.operand_form  = FM_KEY_REG;
          dec.reg_x         = x;
          dec.has_target    = 1'b1;
          dec.branch_target = skip;
        end
      end
      GRP_MISC: begin
        dec.is_valid     = 1'b1;
        dec.operand_form = FM_REG;
        dec.reg_x        = x;
        unique case (kk)
          KK_GDELAY: dec.mnemonic_code = MN_GDELAY;
          KK_WKEY:   dec.mnemonic_code = MN_WKEY;
          KK_SDELAY: dec.mnemonic_code = MN_SDELAY;
          KK_SSOUND: dec.mnemonic_code = MN_SSOUND;
          KK_ADDI: begin
            dec.mnemonic_code = MN_ADD;
            dec.insn_class    = CL_ADD;
            dec.operand_form  = FM_I_REG;
          end
          KK_FONT:   dec.mnemonic_code = MN_FONT;
          KK_XFONT:  dec.mnemonic_code = MN_XFONT;
          KK_BCD:    dec.mnemonic_code = MN_BCD;
          KK_STRA: begin
            dec.mnemonic_code = MN_STRA;
            dec.insn_class    = CL_STORE;
          end
          KK_LDRA: begin
            dec.mnemonic_code = MN_LDRA;
            dec.insn_class    = CL_LOAD;
          end
          default: begin
            dec = '0;
          end
        endcase
      end
      default: begin
        dec = '0;
      end
    endcase
  end

endmodule

// File: rtl/core/chip8_instruction_decoder_core.sv
// Top level of the CHIP-8 / SuperChip instruction decoder: input and result registers.
// A request is taken on any cycle with start high; busy never rises, so one opcode
// can enter every cycle. Its decoded record is shown on out_valid for exactly one
// cycle, after passing the input register and then the decode logic into the result
// register. Results cannot be held off, and requests come out in order.
module chip8_instruction_decoder_core
  import c8dec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [OPC_W-1:0]  in_opcode_word,
  input  logic [ADDR_W-1:0] in_insn_address,
  output logic              out_valid,
  output logic              out_is_valid,
  output logic [MNEM_W-1:0] out_mnemonic_code,
  output logic [CLS_W-1:0]  out_insn_class,
  output logic [FORM_W-1:0] out_operand_form,
  output logic [REG_W-1:0]  out_reg_x,
  output logic [REG_W-1:0]  out_reg_y,
  output logic [IMM_W-1:0]  out_imm_value,
  output logic              out_has_target,
  output logic [ADDR_W-1:0] out_branch_target
);

  logic              in_valid_r;
  logic [OPC_W-1:0]  opcode_r;
  logic [ADDR_W-1:0] address_r;
  logic              res_valid_r;
  dec_t              dec_nxt;
  dec_t              res_r;
  logic              accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= accept;
      res_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      opcode_r  <= in_opcode_word;
      address_r <= in_insn_address;
    end
    if (in_valid_r) begin
      res_r <= dec_nxt;
    end
  end

  c8dec_decode u_decode (
    .opcode  (opcode_r),
    .address (address_r),
    .dec     (dec_nxt)
  );

  assign out_valid         = res_valid_r;
  assign out_is_valid      = res_r.is_valid;
  assign out_mnemonic_code = res_r.mnemonic_code;
  assign out_insn_class    = res_r.insn_class;
  assign out_operand_form  = res_r.operand_form;
  assign out_reg_x         = res_r.reg_x;
  assign out_reg_y         = res_r.reg_y;
  assign out_imm_value     = res_r.imm_value;
  assign out_has_target    = res_r.has_target;
  assign out_branch_target = res_r.branch_target;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid)
    else $error("request did not yield a result two cycles later");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 2))
    else $error("result without a matching request");

  a_invalid_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_valid) |-> (out_mnemonic_code == MN_CLS && !out_has_target
      && out_reg_x == '0 && out_imm_value == '0))
    else $error("invalid opcode carries nonzero fields");

  a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_target) |-> (out_branch_target == '0))
    else $error("branch target set without a target");

  a_skip_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_insn_class == CL_CONDJUMP) |->
      (out_has_target && out_branch_target == $past(in_insn_address, 2) + SKIP_DIST))
    else $error("skip target is not address plus four");

endmodule

// File: test/chip8_instruction_decoder_core_tb.sv
// Self-checking testbench for the CHIP-8 / SuperChip instruction decoder core.
`timescale 1ns / 1ps

module chip8_instruction_decoder_core_tb
  import c8dec_pkg::*;
;

  localparam int RAND_ITEMS   = 1050;
  localparam int CALM_TAIL    = 150;
  localparam int DIR_ROWS     = 28;
  localparam int DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam dec_t DEC_INVALID = '0;

  typedef struct packed {
    logic [OPC_W-1:0]  op;
    logic [ADDR_W-1:0] addr;
    logic              lit;
    dec_t              want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [OPC_W-1:0]  in_opcode_word = '0;
  logic [ADDR_W-1:0] in_insn_address = '0;
  logic              out_valid;
  logic              out_is_valid;
  logic [MNEM_W-1:0] out_mnemonic_code;
  logic [CLS_W-1:0]  out_insn_class;
  logic [FORM_W-1:0] out_operand_form;
  logic [REG_W-1:0]  out_reg_x;
  logic [REG_W-1:0]  out_reg_y;
  logic [IMM_W-1:0]  out_imm_value;
  logic              out_has_target;
  logic [ADDR_W-1:0] out_branch_target;

  logic lit_en = 1'b0;
  dec_t lit_want = '0;

  dec_t expected_decodes[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  logic [3:0] alu_ops [9] = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR,
                              ALU_SUBN, ALU_SHL};
  logic [7:0] misc_kk [10] = '{KK_GDELAY, KK_WKEY, KK_SDELAY, KK_SSOUND, KK_ADDI, KK_FONT,
                               KK_XFONT, KK_BCD, KK_STRA, KK_LDRA};
  logic [7:0] sys_low [6] = '{OP_CLS[7:0], OP_RTS[7:0], OP_SCRIGHT[7:0], OP_SCLEFT[7:0],
                              OP_LOW[7:0], OP_HIGH[7:0]};

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{16'h00E0, 16'h0200, 1'b1,
      '{1'b1, MN_CLS, CL_NONE, FM_NONE, 4'h0, 4'h0, 12'h000, 1'b0, 16'h0000}},
    '{16'h00EE, 16'hFFFE, 1'b1,
      '{1'b1, MN_RTS, CL_STOP, FM_NONE, 4'h0, 4'h0, 12'h000, 1'b0, 16'h0000}},
    '{16'h00FB, 16'h0000, 1'b0, DEC_INVALID},
    '{16'h00FC, 16'h1234, 1'b0, DEC_INVALID},
    '{16'h00FE, 16'hABCD, 1'b0, DEC_INVALID},
    '{16'h00FF, 16'h5555, 1'b0, DEC_INVALID},
    '{16'h00CF, 16'hAAAA, 1'b0, DEC_INVALID},
    '{16'h0FC3, 16'h0202, 1'b0, DEC_INVALID},
    '{16'h0000, 16'h0000, 1'b1,
      '{1'b1, MN_SYS, CL_PRIV, FM_CONST12, 4'h0, 4'h0, 12'h000, 1'b0, 16'h0000}},
    '{16'h1FFF, 16'h0000, 1'b1,
      '{1'b1, MN_JMP, CL_JUMP, FM_TARGET12, 4'h0, 4'h0, 12'hFFF, 1'b1, 16'h0FFF}},
    '{16'h2000, 16'hFFFF, 1'b0, DEC_INVALID},
    '{16'h3AFF, 16'hFFFC, 1'b1,
      '{1'b1, MN_SKE, CL_CONDJUMP, FM_REG_IMM8, 4'hA, 4'h0, 12'h0FF, 1'b1, 16'h0000}},
    '{16'h4F00, 16'hFFFF, 1'b0, DEC_INVALID},
    '{16'h5FF0, 16'h0000, 1'b0, DEC_INVALID},
    '{16'h5121, 16'h0300, 1'b1, DEC_INVALID},
    '{16'h7FFF, 16'h0300, 1'b0, DEC_INVALID},
    '{16'h8126, 16'h0400, 1'b0, DEC_INVALID},
    '{16'h8ABE, 16'h0402, 1'b0, DEC_INVALID},
    '{16'h8458, 16'h0404, 1'b1, DEC_INVALID},
    '{16'h8ABF, 16'h0406, 1'b1, DEC_INVALID},
    '{16'h9AB0, 16'hFFFD, 1'b0, DEC_INVALID},
    '{16'hBFFF, 16'h0500, 1'b0, DEC_INVALID},
    '{16'hD12F, 16'h0502, 1'b0, DEC_INVALID},
    '{16'hE59E, 16'hFFFE, 1'b0, DEC_INVALID},
    '{16'hE5A1, 16'h7FFF, 1'b0, DEC_INVALID},
    '{16'hE500, 16'h0600, 1'b1, DEC_INVALID},
    '{16'hF51E, 16'h8000, 1'b0, DEC_INVALID},
    '{16'hFFFF, 16'hFFFF, 1'b1, DEC_INVALID}
  };

  chip8_instruction_decoder_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode_word    (in_opcode_word),
    .in_insn_address   (in_insn_address),
    .out_valid         (out_valid),
    .out_is_valid      (out_is_valid),
    .out_mnemonic_code (out_mnemonic_code),
    .out_insn_class    (out_insn_class),
    .out_operand_form  (out_operand_form),
    .out_reg_x         (out_reg_x),
    .out_reg_y         (out_reg_y),
    .out_imm_value     (out_imm_value),
    .out_has_target    (out_has_target),
    .out_branch_target (out_branch_target)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic dec_t insn_kind(logic [MNEM_W-1:0] mn, logic [CLS_W-1:0] cl,
                                     logic [FORM_W-1:0] fm);
    dec_t d;
    d = '0;
    d.is_valid      = 1'b1;
    d.mnemonic_code = mn;
    d.insn_class    = cl;
    d.operand_form  = fm;
    return d;
  endfunction

  function automatic dec_t decode_opcode(logic [OPC_W-1:0] op, logic [ADDR_W-1:0] addr);
    dec_t              d;
    logic [3:0]        x;
    logic [3:0]        y;
    logic [3:0]        n;
    logic [7:0]        kk;
    logic [11:0]       nnn;
    logic [ADDR_W-1:0] skip;
    x    = op[11:8];
    y    = op[7:4];
    n    = op[3:0];
    kk   = op[7:0];
    nnn  = op[11:0];
    skip = addr + SKIP_DIST;
    d    = '0;
    case (op[15:12])
      GRP_SYS: begin
        if (op == OP_CLS) d = insn_kind(MN_CLS, CL_NONE, FM_NONE);
        else if (op == OP_RTS) d = insn_kind(MN_RTS, CL_STOP, FM_NONE);
        else if (op == OP_SCRIGHT) d = insn_kind(MN_SCRIGHT, CL_NONE, FM_NONE);
        else if (op == OP_SCLEFT) d = insn_kind(MN_SCLEFT, CL_NONE, FM_NONE);
        else if (op == OP_LOW) d = insn_kind(MN_LOW, CL_NONE, FM_NONE);
        else if (op == OP_HIGH) d = insn_kind(MN_HIGH, CL_NONE, FM_NONE);
        else if (op[15:4] == OP_SCDOWN_HI) begin
          d = insn_kind(MN_SCDOWN, CL_NONE, FM_NIBBLE);
          d.imm_value = {8'h00, n};
        end else begin
          d = insn_kind(MN_SYS, CL_PRIV, FM_CONST12);
          d.imm_value = nnn;
        end
      end
      GRP_JMP, GRP_CALL: begin
        if (op[15:12] == GRP_JMP) d = insn_kind(MN_JMP, CL_JUMP, FM_TARGET12);
        else d = insn_kind(MN_CALL, CL_CALL, FM_TARGET12);
        d.imm_value     = nnn;
        d.has_target    = 1'b1;
        d.branch_target = {4'h0, nnn};
      end
      GRP_SKEI, GRP_SKNEI: begin
        if (op[15:12] == GRP_SKEI) d = insn_kind(MN_SKE, CL_CONDJUMP, FM_REG_IMM8);
        else d = insn_kind(MN_SKNE, CL_CONDJUMP, FM_REG_IMM8);
        d.reg_x         = x;
        d.imm_value     = {4'h0, kk};
        d.has_target    = 1'b1;
        d.branch_target = skip;
      end
      GRP_SKER, GRP_SKNER: begin
        if (n == 4'h0) begin
          if (op[15:12] == GRP_SKER) d = insn_kind(MN_SKE, CL_CONDJUMP, FM_REG_SKIP);
          else d = insn_kind(MN_SKNE, CL_CONDJUMP, FM_REG_SKIP);
          d.reg_x         = x;
          d.reg_y         = y;
          d.has_target    = 1'b1;
          d.branch_target = skip;
        end
      end
      GRP_MOVI, GRP_ADDI, GRP_RAND: begin
        if (op[15:12] == GRP_MOVI) d = insn_kind(MN_MOV, CL_LOAD, FM_REG_C8);
        else if (op[15:12] == GRP_ADDI) d = insn_kind(MN_ADD, CL_ADD, FM_REG_C8);
        else d = insn_kind(MN_RAND, CL_NONE, FM_REG_C8);
        d.reg_x     = x;
        d.imm_value = {4'h0, kk};
      end
      GRP_ALU: begin
        case (n)
          ALU_MOV:  d = insn_kind(MN_MOV, CL_LOAD, FM_REG_REG);
          ALU_OR:   d = insn_kind(MN_OR, CL_OR, FM_REG_REG);
          ALU_AND:  d = insn_kind(MN_AND, CL_AND, FM_REG_REG);
          ALU_XOR:  d = insn_kind(MN_XOR, CL_XOR, FM_REG_REG);
          ALU_ADD:  d = insn_kind(MN_ADD, CL_ADD, FM_REG_REG);
          ALU_SUB:  d = insn_kind(MN_SUB, CL_SUB, FM_REG_REG);
          ALU_SHR:  d = insn_kind(MN_SHR, CL_NONE, FM_REG);
          ALU_SUBN: d = insn_kind(MN_SUB, CL_SUB, FM_REG_REG);
          ALU_SHL:  d = insn_kind(MN_SHL, CL_NONE, FM_REG);
          default:  d = '0;
        endcase
        if (d.is_valid) begin
          d.reg_x = x;
          if (d.operand_form == FM_REG_REG) d.reg_y = y;
        end
      end
      GRP_LDI: begin
        d = insn_kind(MN_MOV, CL_LOAD, FM_I_C12);
        d.imm_value = nnn;
      end
      GRP_JMPV: begin
        d = insn_kind(MN_JMP, CL_JUMP, FM_V0_DISP);
        d.imm_value = nnn;
      end
      GRP_DRAW: begin
        d = insn_kind(MN_DRAW, CL_NONE, FM_REG_REG_N);
        d.reg_x     = x;
        d.reg_y     = y;
        d.imm_value = {8'h00, n};
      end
      GRP_KEY: begin
        if (kk == KK_SKP) d = insn_kind(MN_SKP, CL_CONDJUMP, FM_KEY_REG);
        else if (kk == KK_SKNP) d = insn_kind(MN_SKNP, CL_CONDJUMP, FM_KEY_REG);
        if (d.is_valid) begin
          d.reg_x         = x;
          d.has_target    = 1'b1;
          d.branch_target = skip;
        end
      end
      default: begin
        case (kk)
          KK_GDELAY: d = insn_kind(MN_GDELAY, CL_NONE, FM_REG);
          KK_WKEY:   d = insn_kind(MN_WKEY, CL_NONE, FM_REG);
          KK_SDELAY: d = insn_kind(MN_SDELAY, CL_NONE, FM_REG);
          KK_SSOUND: d = insn_kind(MN_SSOUND, CL_NONE, FM_REG);
          KK_ADDI:   d = insn_kind(MN_ADD, CL_ADD, FM_I_REG);
          KK_FONT:   d = insn_kind(MN_FONT, CL_NONE, FM_REG);
          KK_XFONT:  d = insn_kind(MN_XFONT, CL_NONE, FM_REG);
          KK_BCD:    d = insn_kind(MN_BCD, CL_NONE, FM_REG);
          KK_STRA:   d = insn_kind(MN_STRA, CL_STORE, FM_REG);
          KK_LDRA:   d = insn_kind(MN_LDRA, CL_LOAD, FM_REG);
          default:   d = '0;
        endcase
        if (d.is_valid) d.reg_x = x;
      end
    endcase
    return d;
  endfunction

  function automatic logic [OPC_W-1:0] random_opcode();
    logic [OPC_W-1:0] op;
    op = 16'($urandom);
    if ($urandom_range(0, 3) == 0) return op;
    case (op[15:12])
      GRP_SYS: begin
        case ($urandom_range(0, 2))
          0: op = {8'h00, sys_low[$urandom_range(0, 5)]};
          1: op = {OP_SCDOWN_HI, op[3:0]};
          default: ;
        endcase
      end
      GRP_SKER, GRP_SKNER: if ($urandom_range(0, 3) != 0) op[3:0] = 4'h0;
      GRP_ALU: if ($urandom_range(0, 3) != 0) op[3:0] = alu_ops[$urandom_range(0, 8)];
      GRP_KEY: begin
        if ($urandom_range(0, 3) != 0) op[7:0] = $urandom_range(0, 1) ? KK_SKP : KK_SKNP;
      end
      GRP_MISC: if ($urandom_range(0, 3) != 0) op[7:0] = misc_kk[$urandom_range(0, 9)];
      default: ;
    endcase
    return op;
  endfunction

  task automatic flag_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    $display("%0t: decode mismatch on %s: expected %h, got %h", $time, what, want, got);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) flag_mismatch(what, want, got);
  endtask

  task automatic issue_request(input logic [OPC_W-1:0] op, input logic [ADDR_W-1:0] addr,
                               input logic lit, input dec_t want);
    start           <= 1'b1;
    in_opcode_word  <= op;
    in_insn_address <= addr;
    lit_en          <= lit;
    lit_want        <= want;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic hold_off(input int cycles);
    start           <= 1'b0;
    in_opcode_word  <= 16'($urandom);
    in_insn_address <= 16'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  always @(posedge clk) begin
    dec_t want;
    if (rst_n && start && busy === 1'b0) begin
      if (lit_en) expected_decodes.push_back(lit_want);
      else expected_decodes.push_back(decode_opcode(in_opcode_word, in_insn_address));
    end
    if (rst_n && out_valid === 1'b1) begin
      if (expected_decodes.size() == 0) begin
        flag_mismatch("unexpected result", 16'h0, {4'h0, out_reg_x, out_reg_y, 4'h0});
      end else begin
        want = expected_decodes.pop_front();
        check_field("is_valid", 16'(want.is_valid), 16'(out_is_valid));
        check_field("mnemonic_code", 16'(want.mnemonic_code), 16'(out_mnemonic_code));
        check_field("insn_class", 16'(want.insn_class), 16'(out_insn_class));
        check_field("operand_form", 16'(want.operand_form), 16'(out_operand_form));
        check_field("reg_x", 16'(want.reg_x), 16'(out_reg_x));
        check_field("reg_y", 16'(want.reg_y), 16'(out_reg_y));
        check_field("imm_value", 16'(want.imm_value), 16'(out_imm_value));
        check_field("has_target", 16'(want.has_target), 16'(out_has_target));
        check_field("branch_target", want.branch_target, out_branch_target);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int               idle_pct;
    logic [ADDR_W-1:0] addr;
    idle_pct = 30;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if ($urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 6));
      issue_request(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].lit, dir_rows[i].want);
    end

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 100 == 0) idle_pct = $urandom_range(0, 1) ? 0 : 35;
      if (i < RAND_ITEMS - CALM_TAIL && $urandom_range(0, 99) < idle_pct) begin
        hold_off($urandom_range(1, 6));
      end
      addr = ($urandom_range(0, 7) == 0) ? 16'hFFFC + 16'($urandom_range(0, 3))
                                         : 16'($urandom);
      issue_request(random_opcode(), addr, 1'b0, DEC_INVALID);
    end

    start <= 1'b0;
    @(posedge clk);
    while (expected_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
